// ===== src/lz4bd_pkg.sv =====
// Shared types and constants of the LZ4 block decoder.
// Depends on nothing; every other file of the decoder but lz4bd_history refers to it by scoped names.
package lz4bd_pkg;

    // Command codes of an input request
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Error codes, sticky until the next block start
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SHORT   = 3'd1;
    localparam logic [2:0] ERR_OVERRUN = 3'd2;
    localparam logic [2:0] ERR_OFFSET  = 3'd3;
    localparam logic [2:0] ERR_TURN    = 3'd4;

    // Header field constants
    localparam logic [3:0] NIBBLE_EXT = 4'hf;
    localparam logic [7:0] BYTE_EXT   = 8'd255;
    localparam logic [8:0] MIN_MATCH  = 9'd4;

    // Parser phases
    typedef enum logic [7:0] {
        PH_TOKEN  = 8'b0000_0001,
        PH_LITEXT = 8'b0000_0010,
        PH_LIT    = 8'b0000_0100,
        PH_OFFLO  = 8'b0000_1000,
        PH_OFFHI  = 8'b0001_0000,
        PH_MATEXT = 8'b0010_0000,
        PH_COPY   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    // One input request
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] src_byte;
        logic       last_source;
    } cmd_t;

    // One result
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       copy_pending;
        logic       done_res;
        logic       last_output;
        logic [2:0] error_code;
    } res_t;

    // Parser decision for one accepted request, handed to the output stage
    typedef struct packed {
        logic       emit;
        logic       is_copy;
        logic [7:0] lit_byte;
        logic       copy_pending;
        logic       done_res;
        logic       last_output;
        logic [2:0] error_code;
    } step_t;

endpackage

// ===== src/lz4_block_decoder.sv =====
// LZ4 raw block decoder top level: parser, history store and output stage.
// Depends on lz4bd_pkg, lz4bd_parser and lz4bd_history.
//
// Takes one request per clock unless the result side stalls (compressed byte,
// copy tick or block start) and gives exactly one result per request. Each
// request passes through the decode stage register and then the result
// register before res_valid rises. With res_ready held high the sustained
// rate is one request per cycle, including copy ticks of overlapping matches.
// The parser decides each request in the cycle it is accepted and issues the
// history read; the decode stage then picks the literal or the history byte and,
// as it leaves, writes it back into the 2^WINDOW_BITS byte history store,
// whose single read and single write port per cycle set that rate. A copy that
// reads the byte written in the same cycle (offset 1) is served by a bypass.
// The history store is not cleared after reset; a match only reads bytes
// decoded earlier in the same block. Write output_length through the
// configuration port only while no request is in flight.
module lz4_block_decoder #(
    parameter int WINDOW_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  lz4bd_pkg::cmd_t cmd_data,
    output logic            res_valid,
    input  logic            res_ready,
    output lz4bd_pkg::res_t res_data
);

    lz4bd_pkg::step_t       step;
    logic [WINDOW_BITS-1:0] rd_addr;
    logic [WINDOW_BITS-1:0] wr_addr;
    logic                   accept;
    logic                   s1_move;
    logic [7:0]             hist_rdata;
    logic [7:0]             s1_byte;
    logic                   hist_we;

    logic                   s1_valid_reg, s1_valid_next;
    lz4bd_pkg::step_t       s1_step_reg;
    logic [WINDOW_BITS-1:0] s1_waddr_reg;
    logic                   res_valid_reg, res_valid_next;
    lz4bd_pkg::res_t        res_data_reg, res_data_next;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Take a request when the decode stage is empty or draining
    assign s1_move   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || s1_move;
    assign accept    = cmd_valid && cmd_ready;

    lz4bd_parser #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_data  (cmd_data),
        .accept    (accept),
        .step      (step),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    // Write each decoded byte as it leaves the decode stage
    assign s1_byte = s1_step_reg.is_copy ? hist_rdata : s1_step_reg.lit_byte;
    assign hist_we = s1_move && s1_step_reg.emit;

    lz4bd_history #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_we),
        .wr_addr (s1_waddr_reg),
        .wr_data (s1_byte),
        .rd_en   (accept && step.is_copy),
        .rd_addr (rd_addr),
        .rd_data (hist_rdata)
    );

    // Advance the decode stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Build the result and hold it until taken
    always_comb
    begin
        res_data_next.out_valid    = s1_step_reg.emit;
        res_data_next.out_byte     = s1_step_reg.emit ? s1_byte : '0;
        res_data_next.copy_pending = s1_step_reg.copy_pending;
        res_data_next.done_res     = s1_step_reg.done_res;
        res_data_next.last_output  = s1_step_reg.last_output;
        res_data_next.error_code   = s1_step_reg.error_code;

        res_valid_next = res_valid_reg;
        if (s1_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_step_reg  <= step;
            s1_waddr_reg <= wr_addr;
        end
        if (s1_move)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // A history write always lands its byte in the result register
    a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |=> res_valid_reg && res_data_reg.out_valid)
        else $error("history write without a matching decoded result");

    // An accepted request occupies the decode stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before decode");

    // Status flags are exclusive and cleared under an error
    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.error_code != lz4bd_pkg::ERR_NONE
        |-> !res_data_reg.copy_pending && !res_data_reg.done_res)
        else $error("status flag set alongside an error");

    // The final byte is a real byte and completes the block
    a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.last_output
        |-> res_data_reg.out_valid && !res_data_reg.copy_pending)
        else $error("last_output on a result without a final byte");

    // No byte means a zero byte field
    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_data_reg.out_valid |-> res_data_reg.out_byte == 8'h00)
        else $error("byte field set without a decoded byte");

endmodule

// ===== src/lz4bd_parser.sv =====
// Token, length and offset parser with the block counters of the LZ4 decoder.
// Depends on lz4bd_pkg; drives the history read address and the output stage.
module lz4bd_parser #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [31:0]            cfg_data,
    input  lz4bd_pkg::cmd_t        cmd_data,
    input  logic                   accept,
    output lz4bd_pkg::step_t       step,
    output logic [WINDOW_BITS-1:0] rd_addr,
    output logic [WINDOW_BITS-1:0] wr_addr
);

    localparam logic [32:0] WinSize = 33'(2 ** WINDOW_BITS);

    lz4bd_pkg::phase_t phase_reg, phase_next, ph_eff;
    logic [3:0]  nibble_reg, nibble_next;
    logic [31:0] lit_rem_reg, lit_rem_next;
    logic [31:0] mat_rem_reg, mat_rem_next;
    logic [15:0] offset_reg, offset_next;
    logic [31:0] prod_reg, prod_next;
    logic [2:0]  err_reg, err_next;
    logic        ended_reg, ended_next;
    logic [31:0] out_len_reg;

    logic [32:0] room_diff;
    logic [31:0] room;
    logic [31:0] prod_inc;
    logic [31:0] lit_len;
    logic [31:0] mat_ext;
    logic [31:0] mat_len;
    logic [15:0] off_full;
    logic [7:0]  b;
    logic        emit;
    logic        is_copy;

    // Add with saturation at the full 32-bit range
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [8:0] v);
        logic [32:0] s;
        s = {1'b0, a} + {24'h0, v};
        return s[32] ? '1 : s[31:0];
    endfunction

    // Bytes still owed to the block
    assign room_diff = {1'b0, out_len_reg} - {1'b0, prod_reg};
    assign room      = room_diff[32] ? '0 : room_diff[31:0];
    assign prod_inc  = prod_reg + 32'd1;
    assign b         = cmd_data.src_byte;
    assign off_full  = {b, offset_reg[7:0]};

    // Match length candidates: header nibble or extension byte, both plus the minimum, cut to the room
    always_comb
    begin
        mat_ext = sat_add(mat_rem_reg, {1'b0, b} + lz4bd_pkg::MIN_MATCH);
        mat_len = {28'h0, nibble_reg} + 32'(lz4bd_pkg::MIN_MATCH);
        if (ph_eff == lz4bd_pkg::PH_MATEXT)
        begin
            mat_len = mat_ext;
        end
        if (mat_len > room)
        begin
            mat_len = room;
        end
    end

    // Literal length after this byte
    always_comb
    begin
        if (ph_eff == lz4bd_pkg::PH_TOKEN)
        begin
            lit_len = {28'h0, b[7:4]};
        end
        else
        begin
            lit_len = sat_add(lit_rem_reg, {1'b0, b});
        end
    end

    // Decide the next parser state for the request on the input
    always_comb
    begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        lit_rem_next = lit_rem_reg;
        mat_rem_next = mat_rem_reg;
        offset_next  = offset_reg;
        prod_next    = prod_reg;
        err_next     = err_reg;
        ended_next   = ended_reg;
        emit         = 1'b0;
        is_copy      = 1'b0;
        ph_eff       = phase_reg;

        if (phase_reg == lz4bd_pkg::PH_TOKEN && prod_reg >= out_len_reg)
        begin
            ph_eff = lz4bd_pkg::PH_DONE;
        end

        if (cmd_data.command == lz4bd_pkg::CMD_START)
        begin
            phase_next   = (out_len_reg == '0) ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_TOKEN;
            nibble_next  = '0;
            lit_rem_next = '0;
            mat_rem_next = '0;
            offset_next  = '0;
            prod_next    = '0;
            err_next     = lz4bd_pkg::ERR_NONE;
            ended_next   = 1'b0;
        end
        else if (err_reg == lz4bd_pkg::ERR_NONE)
        begin
            phase_next = ph_eff;
            priority if (ph_eff == lz4bd_pkg::PH_DONE)
            begin
                // drop everything once the block is complete
            end
            else if (cmd_data.command == lz4bd_pkg::CMD_TICK)
            begin
                if (ph_eff == lz4bd_pkg::PH_COPY)
                begin
                    emit         = 1'b1;
                    is_copy      = 1'b1;
                    prod_next    = prod_inc;
                    mat_rem_next = mat_rem_reg - 32'd1;
                    if (prod_inc >= out_len_reg)
                    begin
                        phase_next = lz4bd_pkg::PH_DONE;
                    end
                    else if (mat_rem_next == '0)
                    begin
                        phase_next = lz4bd_pkg::PH_TOKEN;
                        if (ended_reg)
                        begin
                            err_next = lz4bd_pkg::ERR_SHORT;
                        end
                    end
                end
                else
                begin
                    err_next = lz4bd_pkg::ERR_TURN;
                end
            end
            else if (cmd_data.command == lz4bd_pkg::CMD_BYTE)
            begin
                unique case (ph_eff)
                    lz4bd_pkg::PH_TOKEN, lz4bd_pkg::PH_LITEXT:
                    begin
                        if (ph_eff == lz4bd_pkg::PH_TOKEN)
                        begin
                            nibble_next = b[3:0];
                        end
                        lit_rem_next = lit_len;
                        if (ph_eff == lz4bd_pkg::PH_TOKEN && b[7:4] == lz4bd_pkg::NIBBLE_EXT)
                        begin
                            phase_next = lz4bd_pkg::PH_LITEXT;
                        end
                        else if (ph_eff == lz4bd_pkg::PH_LITEXT && b == lz4bd_pkg::BYTE_EXT)
                        begin
                            phase_next = lz4bd_pkg::PH_LITEXT;
                        end
                        else if (lit_len > room)
                        begin
                            err_next = lz4bd_pkg::ERR_OVERRUN;
                        end
                        else if (lit_len == '0)
                        begin
                            phase_next = lz4bd_pkg::PH_OFFLO;
                        end
                        else
                        begin
                            phase_next = lz4bd_pkg::PH_LIT;
                        end
                    end
                    lz4bd_pkg::PH_LIT:
                    begin
                        emit         = 1'b1;
                        prod_next    = prod_inc;
                        lit_rem_next = lit_rem_reg - 32'd1;
                        if (prod_inc >= out_len_reg)
                        begin
                            phase_next = lz4bd_pkg::PH_DONE;
                        end
                        else if (lit_rem_next == '0)
                        begin
                            phase_next = lz4bd_pkg::PH_OFFLO;
                        end
                    end
                    lz4bd_pkg::PH_OFFLO:
                    begin
                        offset_next = {8'h0, b};
                        phase_next  = lz4bd_pkg::PH_OFFHI;
                    end
                    lz4bd_pkg::PH_OFFHI:
                    begin
                        offset_next = off_full;
                        if (off_full == '0 || {16'h0, off_full} > prod_reg
                            || {17'h0, off_full} > WinSize)
                        begin
                            err_next = lz4bd_pkg::ERR_OFFSET;
                        end
                        else if (nibble_reg == lz4bd_pkg::NIBBLE_EXT)
                        begin
                            mat_rem_next = 32'(lz4bd_pkg::NIBBLE_EXT);
                            phase_next   = lz4bd_pkg::PH_MATEXT;
                        end
                        else
                        begin
                            mat_rem_next = mat_len;
                            phase_next   = (mat_len == '0) ? lz4bd_pkg::PH_DONE
                                                           : lz4bd_pkg::PH_COPY;
                        end
                    end
                    lz4bd_pkg::PH_MATEXT:
                    begin
                        if (b == lz4bd_pkg::BYTE_EXT)
                        begin
                            mat_rem_next = sat_add(mat_rem_reg, {1'b0, b});
                        end
                        else
                        begin
                            mat_rem_next = mat_len;
                            phase_next   = (mat_len == '0) ? lz4bd_pkg::PH_DONE
                                                           : lz4bd_pkg::PH_COPY;
                        end
                    end
                    default:
                    begin
                        // a byte while a match is pending
                        err_next = lz4bd_pkg::ERR_TURN;
                    end
                endcase

                // flag a source that ends inside a header or literal run
                if (cmd_data.last_source)
                begin
                    ended_next = 1'b1;
                    if (err_next == lz4bd_pkg::ERR_NONE && phase_next != lz4bd_pkg::PH_COPY
                        && phase_next != lz4bd_pkg::PH_DONE)
                    begin
                        err_next = lz4bd_pkg::ERR_SHORT;
                    end
                end
            end
            else
            begin
                err_next = lz4bd_pkg::ERR_TURN;
            end
        end
    end

    // Result fields known at accept time
    always_comb
    begin
        step.emit         = emit;
        step.is_copy      = is_copy;
        step.lit_byte     = b;
        step.last_output  = emit && (prod_inc == out_len_reg);
        step.copy_pending = (err_next == lz4bd_pkg::ERR_NONE) && (phase_next == lz4bd_pkg::PH_COPY);
        step.done_res     = (err_next == lz4bd_pkg::ERR_NONE) && (phase_next == lz4bd_pkg::PH_DONE);
        step.error_code   = err_next;
    end

    // History addresses: copy source and the slot of the byte produced now
    assign rd_addr = prod_reg[WINDOW_BITS-1:0] - offset_reg[WINDOW_BITS-1:0];
    assign wr_addr = prod_reg[WINDOW_BITS-1:0];

    // Advance the parser state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lz4bd_pkg::PH_TOKEN;
            nibble_reg  <= '0;
            lit_rem_reg <= '0;
            mat_rem_reg <= '0;
            offset_reg  <= '0;
            prod_reg    <= '0;
            err_reg     <= lz4bd_pkg::ERR_NONE;
            ended_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            lit_rem_reg <= lit_rem_next;
            mat_rem_reg <= mat_rem_next;
            offset_reg  <= offset_next;
            prod_reg    <= prod_next;
            err_reg     <= err_next;
            ended_reg   <= ended_next;
        end
    end

    // Hold the configured output length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            out_len_reg <= cfg_data;
        end
    end

endmodule

// ===== src/lz4bd_history.sv =====
// History store of the LZ4 decoder: one synchronous write and one read per cycle.
// Depends on nothing; a read of the entry written in the same cycle returns the new byte.
module lz4bd_history #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [WINDOW_BITS-1:0] wr_addr,
    input  logic [7:0]             wr_data,
    input  logic                   rd_en,
    input  logic [WINDOW_BITS-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    localparam int Depth = 2 ** WINDOW_BITS;

    logic [7:0] mem [Depth];
    logic [7:0] q_reg;
    logic       byp_reg;
    logic [7:0] byp_data_reg;

    // Write decoded bytes, read copy sources
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // Bypass a read that hits the entry being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

// ===== test/lz4bd_checker.sv =====
// Checker of the LZ4 block decoder: watches the configuration, request and result channels,
// predicts every result with its own decoder state and compares it field by field.
// Depends on lz4bd_pkg for the request and result types and the codes.
`timescale 1ns / 100ps

module lz4bd_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [31:0]     cfg_data,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  lz4bd_pkg::cmd_t cmd_data,
    input  logic            res_valid,
    input  logic            res_ready,
    input  lz4bd_pkg::res_t res_data,
    output int              fail_count,
    output int              pending,
    output int              live_items
);

    localparam int MAX_REPORTS = 40;

    // Mirrored decoder state
    logic [31:0]       out_len;
    lz4bd_pkg::phase_t phase;
    logic [3:0]        match_nib;
    logic [31:0]       lit_left;
    logic [31:0]       copy_left;
    logic [15:0]       match_dist;
    logic [31:0]       produced;
    logic [2:0]        err;
    logic              src_ended;
    logic [7:0]        history [0:65535];

    // Decoded results still owed by the block, oldest first
    lz4bd_pkg::res_t decoded_q [$];
    int              fails;
    int              lives;

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] room_left();
        return (out_len > produced) ? out_len - produced : 32'd0;
    endfunction

    // Write a decoded byte into the history and put it on the result
    task automatic emit(input logic [7:0] b, inout lz4bd_pkg::res_t r);
        history[produced[15:0]] = b;
        produced = produced + 32'd1;
        r.out_valid = 1'b1;
        r.out_byte = b;
        r.last_output = (produced == out_len);
    endtask

    // Reject a literal run longer than the bytes still owed, else enter the offset or literal phase
    task automatic close_lit_header();
        if (lit_left > room_left())
            err = lz4bd_pkg::ERR_OVERRUN;
        else if (lit_left == 32'd0)
            phase = lz4bd_pkg::PH_OFFLO;
        else
            phase = lz4bd_pkg::PH_LIT;
    endtask

    // Add the minimum match and cut the match at the end of the block
    task automatic close_match_header();
        logic [31:0] m;
        m = sat_sum(copy_left, {23'd0, lz4bd_pkg::MIN_MATCH});
        if (m > room_left())
            m = room_left();
        copy_left = m;
        phase = (m == 32'd0) ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_COPY;
    endtask

    task automatic take_src(input logic [7:0] b, inout lz4bd_pkg::res_t r);
        logic [15:0] span;
        case (phase)
            lz4bd_pkg::PH_TOKEN:
            begin
                match_nib = b[3:0];
                lit_left = {28'd0, b[7:4]};
                if (b[7:4] == lz4bd_pkg::NIBBLE_EXT)
                    phase = lz4bd_pkg::PH_LITEXT;
                else
                    close_lit_header();
            end
            lz4bd_pkg::PH_LITEXT:
            begin
                lit_left = sat_sum(lit_left, {24'd0, b});
                if (b != lz4bd_pkg::BYTE_EXT)
                    close_lit_header();
            end
            lz4bd_pkg::PH_LIT:
            begin
                emit(b, r);
                lit_left = lit_left - 32'd1;
                if (produced >= out_len)
                    phase = lz4bd_pkg::PH_DONE;
                else if (lit_left == 32'd0)
                    phase = lz4bd_pkg::PH_OFFLO;
            end
            lz4bd_pkg::PH_OFFLO:
            begin
                match_dist = {8'd0, b};
                phase = lz4bd_pkg::PH_OFFHI;
            end
            lz4bd_pkg::PH_OFFHI:
            begin
                // a 16-bit distance never exceeds the full window
                span = {b, match_dist[7:0]};
                match_dist = span;
                if (span == 16'd0 || {16'd0, span} > produced)
                    err = lz4bd_pkg::ERR_OFFSET;
                else if (match_nib == lz4bd_pkg::NIBBLE_EXT)
                begin
                    copy_left = {28'd0, lz4bd_pkg::NIBBLE_EXT};
                    phase = lz4bd_pkg::PH_MATEXT;
                end
                else
                begin
                    copy_left = {28'd0, match_nib};
                    close_match_header();
                end
            end
            lz4bd_pkg::PH_MATEXT:
            begin
                copy_left = sat_sum(copy_left, {24'd0, b});
                if (b != lz4bd_pkg::BYTE_EXT)
                    close_match_header();
            end
            default:
            begin
                // byte while a copy is pending
                err = lz4bd_pkg::ERR_TURN;
            end
        endcase
    endtask

    // Copy one byte from the history, overlapping copies included
    task automatic copy_one(inout lz4bd_pkg::res_t r);
        logic [15:0] pos;
        pos = produced[15:0] - match_dist;
        emit(history[pos], r);
        copy_left = copy_left - 32'd1;
        if (produced >= out_len)
            phase = lz4bd_pkg::PH_DONE;
        else if (copy_left == 32'd0)
        begin
            phase = lz4bd_pkg::PH_TOKEN;
            if (src_ended)
                err = lz4bd_pkg::ERR_SHORT;
        end
    endtask

    // Advance the decoder by one request and form its result
    task automatic decode_request(input lz4bd_pkg::cmd_t c, output lz4bd_pkg::res_t r);
        r = '0;
        if (c.command == lz4bd_pkg::CMD_START)
        begin
            phase = (out_len == 32'd0) ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_TOKEN;
            match_nib = 4'd0;
            lit_left = 32'd0;
            copy_left = 32'd0;
            match_dist = 16'd0;
            produced = 32'd0;
            err = lz4bd_pkg::ERR_NONE;
            src_ended = 1'b0;
        end
        else if (err == lz4bd_pkg::ERR_NONE)
        begin
            if (phase == lz4bd_pkg::PH_TOKEN && produced >= out_len)
                phase = lz4bd_pkg::PH_DONE;
            if (phase == lz4bd_pkg::PH_DONE)
            begin
                // drop everything once the block is complete
            end
            else if (c.command == lz4bd_pkg::CMD_TICK)
            begin
                if (phase == lz4bd_pkg::PH_COPY)
                    copy_one(r);
                else
                    err = lz4bd_pkg::ERR_TURN;
            end
            else if (c.command == lz4bd_pkg::CMD_BYTE)
            begin
                take_src(c.src_byte, r);
                if (c.last_source)
                begin
                    src_ended = 1'b1;
                    if (err == lz4bd_pkg::ERR_NONE && phase != lz4bd_pkg::PH_COPY
                        && phase != lz4bd_pkg::PH_DONE)
                        err = lz4bd_pkg::ERR_SHORT;
                end
            end
            else
                err = lz4bd_pkg::ERR_TURN;
        end
        r.copy_pending = (err == lz4bd_pkg::ERR_NONE && phase == lz4bd_pkg::PH_COPY);
        r.done_res = (err == lz4bd_pkg::ERR_NONE && phase == lz4bd_pkg::PH_DONE);
        r.error_code = err;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lz4bd_pkg::res_t want;
        if (!rst_n)
        begin
            out_len = 32'd0;
            phase = lz4bd_pkg::PH_TOKEN;
            match_nib = 4'd0;
            lit_left = 32'd0;
            copy_left = 32'd0;
            match_dist = 16'd0;
            produced = 32'd0;
            err = lz4bd_pkg::ERR_NONE;
            src_ended = 1'b0;
            decoded_q.delete();
            fails = 0;
            lives = 0;
            fail_count <= 0;
            pending <= 0;
            live_items <= 0;
        end
        else
        begin
            // compare a delivered result with the oldest prediction
            if (res_valid && res_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unrequested result, expected none, actual %h",
                                 $time, res_data);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("out_valid", want.out_valid, res_data.out_valid);
                    check_field("out_byte", want.out_byte, res_data.out_byte);
                    check_field("copy_pending", want.copy_pending, res_data.copy_pending);
                    check_field("done_res", want.done_res, res_data.done_res);
                    check_field("last_output", want.last_output, res_data.last_output);
                    check_field("error_code", want.error_code, res_data.error_code);
                end
            end

            if (cfg_valid && cfg_ready)
                out_len = cfg_data;

            // count requests the block acts on, then predict
            if (cmd_valid && cmd_ready)
            begin
                if (cmd_data.command == lz4bd_pkg::CMD_START ||
                    (err == lz4bd_pkg::ERR_NONE && phase != lz4bd_pkg::PH_DONE &&
                     !(phase == lz4bd_pkg::PH_TOKEN && produced >= out_len)))
                    lives++;
                decode_request(cmd_data, want);
                decoded_q.push_back(want);
            end

            fail_count <= fails;
            pending <= decoded_q.size();
            live_items <= lives;
        end
    end

endmodule

// ===== test/lz4_block_decoder_tb.sv =====
// Testbench top of the LZ4 block decoder: clock, reset, request and result traffic, verdict.
// Depends on lz4bd_pkg, lz4_block_decoder and the checker module lz4bd_checker.
`timescale 1ns / 100ps

module lz4_block_decoder_tb;

    // Command code outside the defined set
    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam int LIVE_TARGET = 750;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 5000;

    logic            clk;
    logic            rst_n;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [31:0]     cfg_data;
    logic            cmd_valid;
    logic            cmd_ready;
    lz4bd_pkg::cmd_t cmd_data;
    logic            res_valid;
    logic            res_ready;
    lz4bd_pkg::res_t res_data;

    int fail_count;
    int pending;
    int live_items;
    int send_gap_pct;
    int stall_pct;
    int hold_asks;

    // Requests of the block being sent
    lz4bd_pkg::cmd_t plan [$];

    lz4_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    lz4bd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .fail_count (fail_count),
        .pending    (pending),
        .live_items (live_items)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int hold_seen;
        hold_seen = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run when no channel moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic lz4bd_pkg::cmd_t make_req(input logic [1:0] op, input logic [7:0] b,
                                                 input logic last);
        lz4bd_pkg::cmd_t c;
        c.command = op;
        c.src_byte = b;
        c.last_source = last;
        return c;
    endfunction

    // Append a length extension: a run of 255 bytes and the remainder
    task automatic put_len_ext(input int rest);
        int left;
        left = rest;
        while (left >= 255)
        begin
            plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, lz4bd_pkg::BYTE_EXT, 1'b0));
            left -= 255;
        end
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, left[7:0], 1'b0));
    endtask

    task automatic put_ticks(input int n);
        repeat (n) plan.push_back(make_req(lz4bd_pkg::CMD_TICK, 8'($urandom),
                                           1'($urandom_range(1))));
    endtask

    // Let every result drain, then write the output length
    task automatic write_length(input logic [31:0] v);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send the planned requests; optionally change the length partway through
    task automatic run_plan(input int split, input logic [31:0] late_len);
        int i;
        for (i = 0; i < plan.size(); i++)
        begin
            if (i == split)
                write_length(late_len);
            if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
            begin
                cmd_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
            end
            cmd_valid <= 1'b1;
            cmd_data <= plan[i];
            @(posedge clk);
            while (!cmd_ready) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int          total;
        int          nseq;
        int          lits;
        int          mlen;
        int          span;
        int          s;
        int          i;
        int          roll;
        int          at;
        int          split;
        logic [31:0] len;
        logic [3:0]  lit_nib;
        logic [3:0]  mat_nib;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 32'd0;
        cmd_valid <= 1'b0;
        cmd_data <= '0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_asks = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero length: the block is done at once and drops what follows
        write_length(32'd0);
        plan.delete();
        plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'h00, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'hFF, 1'b1));
        put_ticks(1);
        run_plan(-1, 32'd0);

        // overlapping match cut short by the length; hold the result side meanwhile
        write_length(32'd9);
        plan.delete();
        plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'hFF, 1'b1));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h33, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'hFF, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h80, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h01, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0));
        put_ticks(7);
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h5A, 1'b0));
        hold_asks++;
        run_plan(-1, 32'd0);

        // maximum length: source ends inside a sequence, then an undefined command
        write_length(32'hFFFF_FFFF);
        plan.delete();
        plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'h00, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h10, 1'b0));
        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'h41, 1'b1));
        plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'h00, 1'b0));
        plan.push_back(make_req(CMD_BAD, 8'hA5, 1'b0));
        run_plan(-1, 32'd0);

        while (live_items < LIVE_TARGET)
        begin
            // pick the idling mix for this stretch of the run
            case (live_items * 4 / LIVE_TARGET)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 66;
                    stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct = 66;
                end
                default:
                begin
                    send_gap_pct = 34;
                    stall_pct = 34;
                end
            endcase

            plan.delete();
            total = 0;
            if ($urandom_range(11) == 0)
            begin
                // noise: arbitrary requests after a block start
                plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'($urandom),
                                        1'($urandom_range(1))));
                repeat ($urandom_range(5, 30))
                begin
                    roll = $urandom_range(9);
                    plan.push_back(make_req(roll == 0 ? CMD_BAD
                                            : (roll < 3 ? lz4bd_pkg::CMD_TICK
                                                        : lz4bd_pkg::CMD_BYTE),
                                            8'($urandom), $urandom_range(7) == 0));
                end
                len = $urandom_range(1, 40);
            end
            else
            begin
                // well-formed block: sequences of literals and matches, literals last
                plan.push_back(make_req(lz4bd_pkg::CMD_START, 8'($urandom), 1'b0));
                nseq = $urandom_range(1, 3);
                for (s = 0; s < nseq; s++)
                begin
                    lits = ($urandom_range(11) == 0) ? $urandom_range(15, 270)
                                                     : $urandom_range(0, 14);
                    if (total == 0 && lits == 0 && $urandom_range(7) != 0)
                        lits = $urandom_range(1, 14);
                    if (s == nseq - 1 && lits == 0)
                        lits = $urandom_range(1, 14);
                    mlen = ($urandom_range(11) == 0) ? $urandom_range(19, 280)
                                                     : $urandom_range(4, 24);
                    lit_nib = (lits >= int'(lz4bd_pkg::NIBBLE_EXT)) ? lz4bd_pkg::NIBBLE_EXT
                                                                    : lits[3:0];
                    if (s == nseq - 1)
                        mat_nib = 4'($urandom_range(15));
                    else if (mlen - int'(lz4bd_pkg::MIN_MATCH) >= int'(lz4bd_pkg::NIBBLE_EXT))
                        mat_nib = lz4bd_pkg::NIBBLE_EXT;
                    else
                        mat_nib = 4'(mlen - int'(lz4bd_pkg::MIN_MATCH));
                    plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, {lit_nib, mat_nib}, 1'b0));
                    if (lit_nib == lz4bd_pkg::NIBBLE_EXT)
                        put_len_ext(lits - int'(lz4bd_pkg::NIBBLE_EXT));
                    for (i = 0; i < lits; i++)
                        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, 8'($urandom),
                                                s == nseq - 1 && i == lits - 1));
                    total += lits;
                    if (s < nseq - 1)
                    begin
                        // mostly short distances so copies overlap, now and then a bad one
                        if (total == 0 || $urandom_range(19) == 0)
                            span = $urandom_range(1) ? 0 : total + 1;
                        else if ($urandom_range(2) == 0)
                            span = $urandom_range(1, total < 4 ? total : 4);
                        else
                            span = $urandom_range(1, total);
                        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, span[7:0], 1'b0));
                        plan.push_back(make_req(lz4bd_pkg::CMD_BYTE, span[15:8], 1'b0));
                        if (mat_nib == lz4bd_pkg::NIBBLE_EXT)
                            put_len_ext(mlen - int'(lz4bd_pkg::MIN_MATCH)
                                        - int'(lz4bd_pkg::NIBBLE_EXT));
                        put_ticks(mlen);
                        total += mlen;
                    end
                end

                roll = $urandom_range(19);
                if (roll < 13)
                    len = total;
                else if (roll < 16)
                    len = $urandom_range(1, total - 1);
                else if (roll == 16)
                    len = total + $urandom_range(1, 20);
                else if (roll == 17)
                    len = 32'd0;
                else if (roll == 18)
                    len = 32'hFFFF_FFFF;
                else
                    len = $urandom;

                // break the sequence now and then
                if ($urandom_range(5) == 0)
                begin
                    at = $urandom_range(1, plan.size() - 1);
                    case ($urandom_range(3))
                        0: plan[at] = make_req(2'($urandom_range(3)), 8'($urandom),
                                               1'($urandom_range(1)));
                        1: plan.delete(at);
                        2: plan.insert(at, make_req(lz4bd_pkg::CMD_TICK, 8'($urandom), 1'b0));
                        default: plan[at].last_source = 1'b1;
                    endcase
                end
            end

            write_length(len);
            split = ($urandom_range(9) == 0) ? $urandom_range(1, plan.size() - 1) : -1;
            run_plan(split, $urandom_range(0, total + 4));
        end

        // drain the results, then allow for the output latency
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lz4bd_pkg.sv
src/lz4bd_parser.sv
src/lz4bd_history.sv
src/lz4_block_decoder.sv
test/lz4bd_checker.sv
test/lz4_block_decoder_tb.sv
